// ===== hw/rtl/pfss_pkg.sv =====
// ----------------------------------------------------------------------------
// pfss_pkg
// Types and constants shared by the frame-skip scheduler core, its shared
// divider and its channel interfaces.
// ----------------------------------------------------------------------------
package pfss_pkg;

    localparam int TABLE_SLOTS  = 8;
    localparam int SLOT_W       = 3;
    localparam int FRAME_W      = 31;
    localparam int BUDGET_W     = 10;
    localparam int TOTAL_W      = 12;
    localparam int RATE_W       = 8;
    localparam int WEIGHT_W     = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int CNT_W        = 32;

    // Shared divider: dividend is left-justified, STEP_W counts up to 32 steps
    localparam int DVD_W        = 32;
    localparam int DIV_W        = 16;
    localparam int STEP_W       = 6;

    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 10'd30;
    localparam logic [WEIGHT_W-1:0] WEIGHT_FLOOR = 16'd26;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BUDGET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VALID     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRIO      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_HI = 3'd5;

    typedef enum logic [1:0] {
        PRIO_CRIT   = 2'd0,
        PRIO_NORMAL = 2'd1,
        PRIO_LOW    = 2'd2,
        PRIO_IDLE   = 2'd3
    } prio_t;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DIV_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic              busy;
        logic [DVD_W-1:0]  quotient;
        logic [DIV_W-1:0]  remainder;
    } div_rsp_t;

endpackage

// ===== hw/rtl/pfss_req_if.sv =====
// ----------------------------------------------------------------------------
// pfss_req_if
// Request channel: slot index and frame number.
// ----------------------------------------------------------------------------
interface pfss_req_if;
    logic                          valid;
    logic                          ready;
    logic [pfss_pkg::SLOT_W-1:0]   slot_index;
    logic [pfss_pkg::FRAME_W-1:0]  frame_number;

    modport source (output valid, output slot_index, output frame_number, input ready);
    modport sink   (input valid, input slot_index, input frame_number, output ready);
endinterface

// ===== hw/rtl/pfss_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pfss_rsp_if
// Result channel: one process_frame decision per request.
// ----------------------------------------------------------------------------
interface pfss_rsp_if;
    logic valid;
    logic ready;
    logic process_frame;

    modport source (output valid, output process_frame, input ready);
    modport sink   (input valid, input process_frame, output ready);
endinterface

// ===== hw/rtl/pfss_cfg_if.sv =====
// ----------------------------------------------------------------------------
// pfss_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pfss_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pfss_pkg::CFG_IDX_W-1:0]   index;
    logic [pfss_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/priority_frame_skip_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// priority_frame_skip_scheduler_core
// Answers per client slot whether a frame is processed, from the slot's
// priority class, reserved rate or weight, and a per-slot frame counter.
// ----------------------------------------------------------------------------
// Short paths: an invalid slot, a zero rate or no budget left skip the divider.
// One item at a time: the radix-2 divider runs up to three divisions one bit
//   per cycle; the next item is accepted while its result is presented.
// Reset: registers take their reset values (budget 30, rest zero), slot
//   counters clear at once; no clearing pass, items are taken right away.
// ----------------------------------------------------------------------------
module priority_frame_skip_scheduler_core #(
    parameter int MAX_SLOTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    pfss_req_if.sink    req,
    pfss_rsp_if.source  rsp,
    pfss_cfg_if.sink    cfg
);

    localparam int CNT_DEPTH = (MAX_SLOTS < pfss_pkg::TABLE_SLOTS) ? MAX_SLOTS
                                                                   : pfss_pkg::TABLE_SLOTS;
    localparam int CNT_IDX_W = (CNT_DEPTH > 1) ? $clog2(CNT_DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DECIDE,
        ST_IV,
        ST_MODF,
        ST_MODC,
        ST_DONE
    } state_t;

    // Configuration registers
    logic [pfss_pkg::BUDGET_W-1:0]    budget_reg;
    logic [pfss_pkg::TABLE_SLOTS-1:0] mask_reg;
    logic [2*pfss_pkg::TABLE_SLOTS-1:0] prio_reg;
    logic [pfss_pkg::CFG_DATA_W-1:0]  rate_reg;
    logic [pfss_pkg::CFG_DATA_W-1:0]  wlo_reg;
    logic [pfss_pkg::CFG_DATA_W-1:0]  whi_reg;
    logic [pfss_pkg::TOTAL_W-1:0]     crit_total_reg;
    logic [pfss_pkg::TOTAL_W-1:0]     crit_total_next;

    logic [pfss_pkg::CNT_W-1:0]       cnt_mem [CNT_DEPTH];
    logic                             cnt_we;

    state_t                           state_reg;
    logic [pfss_pkg::SLOT_W-1:0]      slot_reg;
    logic [pfss_pkg::FRAME_W-1:0]     frame_reg;
    logic                             crit_reg;
    logic                             ans_reg;
    logic [pfss_pkg::DIV_W-1:0]       iv_reg;
    logic [pfss_pkg::DIV_W-1:0]       remf_reg;
    logic                             out_valid_reg;
    logic                             out_val_reg;

    pfss_pkg::div_req_t               div_req_reg;
    pfss_pkg::div_rsp_t               div_rsp;

    // Per-slot lookups
    logic                             slot_ok;
    pfss_pkg::prio_t                  slot_prio;
    logic [pfss_pkg::RATE_W-1:0]      slot_rate;
    logic [pfss_pkg::WEIGHT_W-1:0]    slot_weight;
    logic [pfss_pkg::WEIGHT_W-1:0]    weight_fl;
    logic [pfss_pkg::BUDGET_W-1:0]    remain;
    logic [pfss_pkg::DIV_W-1:0]       low_mod;
    logic [pfss_pkg::DIV_W-1:0]       idle_mod;
    logic [pfss_pkg::DIV_W-1:0]       quo_iv;
    logic [pfss_pkg::CNT_W-1:0]       slot_cnt;
    logic [CNT_IDX_W-1:0]             cnt_idx;

    assign cnt_idx     = slot_reg[CNT_IDX_W-1:0];
    assign slot_cnt    = cnt_mem[cnt_idx];
    assign slot_ok     = (32'(slot_reg) < MAX_SLOTS) && mask_reg[slot_reg];
    assign slot_prio   = pfss_pkg::prio_t'(prio_reg[2*slot_reg +: 2]);
    assign slot_rate   = rate_reg[pfss_pkg::RATE_W*slot_reg +: pfss_pkg::RATE_W];
    assign slot_weight = slot_reg[2] ? whi_reg[pfss_pkg::WEIGHT_W*slot_reg[1:0] +: 16]
                                     : wlo_reg[pfss_pkg::WEIGHT_W*slot_reg[1:0] +: 16];
    assign weight_fl   = (slot_weight < pfss_pkg::WEIGHT_FLOOR) ? pfss_pkg::WEIGHT_FLOOR
                                                                : slot_weight;
    assign remain      = budget_reg - crit_total_reg[pfss_pkg::BUDGET_W-1:0];
    assign low_mod     = {5'b0, budget_reg, 1'b0};
    assign idle_mod    = {3'b0, budget_reg, 3'b0} + {5'b0, budget_reg, 1'b0};
    assign quo_iv      = (div_rsp.quotient[pfss_pkg::DIV_W-1:0] == '0)
                         ? pfss_pkg::DIV_W'(1) : div_rsp.quotient[pfss_pkg::DIV_W-1:0];

    // Sum of reserved rates over valid critical slots
    always_comb
    begin
        crit_total_next = '0;
        for (int i = 0; i < pfss_pkg::TABLE_SLOTS; i++)
        begin
            if ((i < MAX_SLOTS) && mask_reg[i]
                && (pfss_pkg::prio_t'(prio_reg[2*i +: 2]) == pfss_pkg::PRIO_CRIT))
            begin
                crit_total_next = crit_total_next
                                  + pfss_pkg::TOTAL_W'(rate_reg[pfss_pkg::RATE_W*i +: 8]);
            end
        end
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg     <= pfss_pkg::BUDGET_RESET;
            mask_reg       <= '0;
            prio_reg       <= '0;
            rate_reg       <= '0;
            wlo_reg        <= '0;
            whi_reg        <= '0;
            crit_total_reg <= '0;
        end
        else
        begin
            crit_total_reg <= crit_total_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    pfss_pkg::REG_BUDGET:    budget_reg <= cfg.data[pfss_pkg::BUDGET_W-1:0];
                    pfss_pkg::REG_VALID:     mask_reg   <= cfg.data[pfss_pkg::TABLE_SLOTS-1:0];
                    pfss_pkg::REG_PRIO:      prio_reg   <= cfg.data[2*pfss_pkg::TABLE_SLOTS-1:0];
                    pfss_pkg::REG_RATE:      rate_reg   <= cfg.data;
                    pfss_pkg::REG_WEIGHT_LO: wlo_reg    <= cfg.data;
                    pfss_pkg::REG_WEIGHT_HI: whi_reg    <= cfg.data;
                    default:                 ;
                endcase
            end
        end
    end

    // Slot counters advance after each critical decision with a nonzero rate
    assign cnt_we = (state_reg == ST_MODC) && div_rsp.done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CNT_DEPTH; i++)
            begin
                cnt_mem[i] <= '0;
            end
        end
        else if (cnt_we)
        begin
            cnt_mem[cnt_idx] <= slot_cnt + 1'b1;
        end
    end

    pfss_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    assign req.ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_req_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_val_reg   <= 1'b0;
            slot_reg      <= '0;
            frame_reg     <= '0;
            crit_reg      <= 1'b0;
            ans_reg       <= 1'b0;
            iv_reg        <= '0;
            remf_reg      <= '0;
        end
        else
        begin
            div_req_reg.start <= 1'b0;
            if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        slot_reg  <= req.slot_index;
                        frame_reg <= req.frame_number;
                        state_reg <= ST_LOAD;
                    end
                end

                // Let the critical total settle after a last register write
                ST_LOAD:
                begin
                    state_reg <= ST_DECIDE;
                end

                ST_DECIDE:
                begin
                    crit_reg <= 1'b0;
                    if (!slot_ok)
                    begin
                        ans_reg   <= 1'b1;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        unique case (slot_prio)
                            pfss_pkg::PRIO_CRIT:
                            begin
                                if (slot_rate == '0)
                                begin
                                    ans_reg   <= 1'b1;
                                    state_reg <= ST_DONE;
                                end
                                else
                                begin
                                    crit_reg             <= 1'b1;
                                    div_req_reg.start    <= 1'b1;
                                    div_req_reg.dividend <= {budget_reg, 22'b0};
                                    div_req_reg.divisor  <= {8'b0, slot_rate};
                                    div_req_reg.steps    <= pfss_pkg::STEP_W'(10);
                                    state_reg            <= ST_IV;
                                end
                            end
                            pfss_pkg::PRIO_NORMAL:
                            begin
                                if ({2'b00, budget_reg} <= crit_total_reg)
                                begin
                                    ans_reg   <= 1'b0;
                                    state_reg <= ST_DONE;
                                end
                                else
                                begin
                                    div_req_reg.start    <= 1'b1;
                                    div_req_reg.dividend <= {remain, 8'b0, 14'b0};
                                    div_req_reg.divisor  <= weight_fl;
                                    div_req_reg.steps    <= pfss_pkg::STEP_W'(18);
                                    state_reg            <= ST_IV;
                                end
                            end
                            pfss_pkg::PRIO_LOW,
                            pfss_pkg::PRIO_IDLE:
                            begin
                                // A zero budget leaves the frame unreduced
                                if (budget_reg == '0)
                                begin
                                    ans_reg   <= (frame_reg == '0);
                                    state_reg <= ST_DONE;
                                end
                                else
                                begin
                                    div_req_reg.start    <= 1'b1;
                                    div_req_reg.dividend <= {frame_reg, 1'b0};
                                    div_req_reg.divisor  <= (slot_prio == pfss_pkg::PRIO_LOW)
                                                            ? low_mod : idle_mod;
                                    div_req_reg.steps    <= pfss_pkg::STEP_W'(31);
                                    state_reg            <= ST_MODF;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end

                ST_IV:
                begin
                    if (div_rsp.done)
                    begin
                        iv_reg               <= quo_iv;
                        div_req_reg.start    <= 1'b1;
                        div_req_reg.dividend <= {frame_reg, 1'b0};
                        div_req_reg.divisor  <= quo_iv;
                        div_req_reg.steps    <= pfss_pkg::STEP_W'(31);
                        state_reg            <= ST_MODF;
                    end
                end

                ST_MODF:
                begin
                    if (div_rsp.done)
                    begin
                        if (crit_reg)
                        begin
                            remf_reg             <= div_rsp.remainder;
                            div_req_reg.start    <= 1'b1;
                            div_req_reg.dividend <= slot_cnt;
                            div_req_reg.divisor  <= iv_reg;
                            div_req_reg.steps    <= pfss_pkg::STEP_W'(32);
                            state_reg            <= ST_MODC;
                        end
                        else
                        begin
                            ans_reg   <= (div_rsp.remainder == '0);
                            state_reg <= ST_DONE;
                        end
                    end
                end

                ST_MODC:
                begin
                    if (div_rsp.done)
                    begin
                        ans_reg   <= (div_rsp.remainder == remf_reg);
                        state_reg <= ST_DONE;
                    end
                end

                // Hold the answer until the output register is free
                ST_DONE:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_val_reg   <= ans_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.process_frame = out_val_reg;

    // Divider completions arrive only while the sequencer waits on one
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_IV) || (state_reg == ST_MODF)
                         || (state_reg == ST_MODC))
        else $error("divider finished outside a wait state");

    // A new division never starts on top of a running one
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        div_req_reg.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    // Counters only move for a valid critical slot with a nonzero rate
    a_cnt_crit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_we |-> crit_reg && slot_ok && (slot_prio == pfss_pkg::PRIO_CRIT)
                   && (slot_rate != '0))
        else $error("slot counter written for a non-critical item");

endmodule

// ===== hw/rtl/pfss_div.sv =====
// ----------------------------------------------------------------------------
// pfss_div
// Radix-2 restoring divider, one quotient bit per cycle. The dividend comes
// left-justified and only the given number of steps is run.
// ----------------------------------------------------------------------------
module pfss_div (
    input  logic               clk,
    input  logic               rst_n,
    input  pfss_pkg::div_req_t req,
    output pfss_pkg::div_rsp_t rsp
);

    logic                        busy_reg;
    logic                        done_reg;
    logic [pfss_pkg::STEP_W-1:0] cnt_reg;
    logic [pfss_pkg::DVD_W-1:0]  quo_reg;
    logic [pfss_pkg::DIV_W-1:0]  rem_reg;
    logic [pfss_pkg::DIV_W-1:0]  dvs_reg;

    logic [pfss_pkg::DIV_W:0]    trial;
    logic [pfss_pkg::DIV_W+1:0]  diff;
    logic                        fits;
    logic [pfss_pkg::DIV_W-1:0]  rem_next;
    logic [pfss_pkg::DVD_W-1:0]  quo_next;

    // Shift the next dividend bit into the partial remainder and try a subtract
    assign trial    = {rem_reg, quo_reg[pfss_pkg::DVD_W-1]};
    assign diff     = {1'b0, trial} - {2'b00, dvs_reg};
    assign fits     = !diff[pfss_pkg::DIV_W+1];
    assign rem_next = fits ? diff[pfss_pkg::DIV_W-1:0] : trial[pfss_pkg::DIV_W-1:0];
    assign quo_next = {quo_reg[pfss_pkg::DVD_W-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == pfss_pkg::STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.busy      = busy_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule
